// ----- design/fac_pkg.sv -----
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types and constants for the frustum box culler: plane and corner
// records, fixed-point widths and request codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fac_pkg;

	// plane count and slot index width
	localparam int NUM_PLANES = 6;
	localparam int PIDX_W     = 3;

	// signed q16.16 values and exact product / sum widths
	localparam int COORD_W = 32;
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int SUM_W   = PROD_W + 2;

	// request codes
	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_TEST = 1'b1
	} req_t;

	// one plane a*x + b*y + c*z + d
	typedef struct packed {
		logic [COORD_W-1:0] a;
		logic [COORD_W-1:0] b;
		logic [COORD_W-1:0] c;
		logic [COORD_W-1:0] d;
	} plane_t;

	// one box corner
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} vec3_t;

	// three exact products of one plane
	typedef struct packed {
		logic [PROD_W-1:0] x;
		logic [PROD_W-1:0] y;
		logic [PROD_W-1:0] z;
	} prod3_t;

endpackage

`default_nettype wire

// ----- design/fac_plane_store.sv -----
// ----------------------------------------------------------------------------
// fac_plane_store
// Register file of frustum planes; at most one slot written per load beat,
// all slots read in parallel. Reset clears every plane to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fac_plane_store (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [fac_pkg::PIDX_W-1:0]  wr_idx,
	input  wire fac_pkg::plane_t             wr_plane,
	output fac_pkg::plane_t                  planes [fac_pkg::NUM_PLANES]
);
	import fac_pkg::*;

	plane_t planes_q [NUM_PLANES];

	// slot write, out-of-range slots are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				planes_q[i] <= '0;
			end
		end else if (wr_en) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				if (wr_idx == PIDX_W'(i)) begin
					planes_q[i] <= wr_plane;
				end
			end
		end
	end

	assign planes = planes_q;

endmodule

`default_nettype wire

// ----- design/fac_mul_stage.sv -----
// ----------------------------------------------------------------------------
// fac_mul_stage
// Positive-vertex selection and the product bank: per plane and axis, picks
// the max corner for a positive coefficient, else the min corner, and
// registers the exact 64-bit products together with the plane constant.
// ----------------------------------------------------------------------------
`default_nettype none

module fac_mul_stage (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire fac_pkg::plane_t            planes [fac_pkg::NUM_PLANES],
	input  wire fac_pkg::vec3_t             box_min,
	input  wire fac_pkg::vec3_t             box_max,
	output fac_pkg::prod3_t                 prod_s2 [fac_pkg::NUM_PLANES],
	output logic [fac_pkg::COORD_W-1:0]     d_s2 [fac_pkg::NUM_PLANES]
);
	import fac_pkg::*;

	vec3_t  pv   [NUM_PLANES];
	prod3_t prod [NUM_PLANES];

	// p-vertex choice and products, one set per plane
	always_comb begin
		for (int i = 0; i < NUM_PLANES; i++) begin
			pv[i].x = ($signed(planes[i].a) > 0) ? box_max.x : box_min.x;
			pv[i].y = ($signed(planes[i].b) > 0) ? box_max.y : box_min.y;
			pv[i].z = ($signed(planes[i].c) > 0) ? box_max.z : box_min.z;
			prod[i].x = PROD_W'($signed(planes[i].a)) * PROD_W'($signed(pv[i].x));
			prod[i].y = PROD_W'($signed(planes[i].b)) * PROD_W'($signed(pv[i].y));
			prod[i].z = PROD_W'($signed(planes[i].c)) * PROD_W'($signed(pv[i].z));
		end
	end

	// product register, d is captured so later loads cannot disturb it
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				prod_s2[i] <= prod[i];
				d_s2[i]    <= planes[i].d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/fac_sum_stage.sv -----
// ----------------------------------------------------------------------------
// fac_sum_stage
// Exact plane sums and the visibility reduction, followed by the output
// register that holds a result beat until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fac_sum_stage (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       valid_s2,
	input  wire fac_pkg::prod3_t            prod_s2 [fac_pkg::NUM_PLANES],
	input  wire logic [fac_pkg::COORD_W-1:0] d_s2 [fac_pkg::NUM_PLANES],
	output logic                            out_valid,
	output logic                            visible
);
	import fac_pkg::*;

	logic signed [SUM_W-1:0]  sum [NUM_PLANES];
	logic [NUM_PLANES-1:0]    pass;
	logic                     valid_q;
	logic                     visible_q;

	// a*x + b*y + c*z + d*2^16, kept exact, only the sign matters
	always_comb begin
		for (int i = 0; i < NUM_PLANES; i++) begin
			sum[i] = SUM_W'($signed(prod_s2[i].x))
				+ SUM_W'($signed(prod_s2[i].y))
				+ SUM_W'($signed(prod_s2[i].z))
				+ (SUM_W'($signed(d_s2[i])) <<< FRAC_W);
			pass[i] = !sum[i][SUM_W-1];
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_s2;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			visible_q <= &pass;
		end
	end

	assign out_valid = valid_q;
	assign visible   = visible_q;

endmodule

`default_nettype wire

// ----- design/frustum_aabb_cull.sv -----
// ----------------------------------------------------------------------------
// frustum_aabb_cull
// Culls axis-aligned boxes against a stored set of frustum planes using the
// positive-vertex test in exact signed q16.16 arithmetic.
//
//   port group   dir  role
//   in_*         in   load beat (writes one plane) or test beat (one box)
//   out_*        out  one visible flag per test beat, none for loads
//
// One beat is accepted per cycle while in_stall is low; a test result passes
// through the input register, the product register behind the 18-multiplier
// bank and the output register.
// Each stage advances on its own, so bubbles close up and input is stalled
// only when all three stages hold beats and the output is stalled.
// Reset clears all planes to zero, so every box tests visible until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_aabb_cull (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        req_type,
	input  wire logic [fac_pkg::PIDX_W-1:0]  plane_index,
	input  wire logic [fac_pkg::COORD_W-1:0] plane_a,
	input  wire logic [fac_pkg::COORD_W-1:0] plane_b,
	input  wire logic [fac_pkg::COORD_W-1:0] plane_c,
	input  wire logic [fac_pkg::COORD_W-1:0] plane_d,
	input  wire logic [fac_pkg::COORD_W-1:0] min_x,
	input  wire logic [fac_pkg::COORD_W-1:0] min_y,
	input  wire logic [fac_pkg::COORD_W-1:0] min_z,
	input  wire logic [fac_pkg::COORD_W-1:0] max_x,
	input  wire logic [fac_pkg::COORD_W-1:0] max_y,
	input  wire logic [fac_pkg::COORD_W-1:0] max_z,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             visible
);
	import fac_pkg::*;

	// stage 1 registers
	logic                 valid_s1;
	req_t                 req_s1;
	logic [PIDX_W-1:0]    idx_s1;
	plane_t               plane_s1;
	vec3_t                min_s1;
	vec3_t                max_s1;

	// stage 2 valid
	logic                 valid_s2;

	// stage enables
	logic                 out_en;
	logic                 s2_en;
	logic                 s1_en;
	logic                 store_wr;

	plane_t               planes  [NUM_PLANES];
	prod3_t               prod_s2 [NUM_PLANES];
	logic [COORD_W-1:0]   d_s2    [NUM_PLANES];

	// per-stage advance, bubbles collapse
	assign out_en   = !out_valid || !out_stall;
	assign s2_en    = !valid_s2 || out_en;
	assign s1_en    = !valid_s1 || s2_en;
	assign in_stall = !s1_en;

	// a load leaves stage 1 in order with tests, so tests see earlier loads only
	assign store_wr = valid_s1 && (req_s1 == REQ_LOAD) && s2_en
		&& (32'(idx_s1) < 32'(NUM_PLANES));

	// stage 1 and stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_en) begin
				valid_s1 <= in_valid;
			end
			if (s2_en) begin
				valid_s2 <= valid_s1 && (req_s1 == REQ_TEST);
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (s1_en && in_valid) begin
			req_s1   <= req_t'(req_type);
			idx_s1   <= plane_index;
			plane_s1 <= '{a: plane_a, b: plane_b, c: plane_c, d: plane_d};
			min_s1   <= '{x: min_x, y: min_y, z: min_z};
			max_s1   <= '{x: max_x, y: max_y, z: max_z};
		end
	end

	fac_plane_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (store_wr),
		.wr_idx   (idx_s1),
		.wr_plane (plane_s1),
		.planes   (planes)
	);

	fac_mul_stage u_mul (
		.clk     (clk),
		.en      (s2_en && valid_s1 && (req_s1 == REQ_TEST)),
		.planes  (planes),
		.box_min (min_s1),
		.box_max (max_s1),
		.prod_s2 (prod_s2),
		.d_s2    (d_s2)
	);

	fac_sum_stage u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (out_en),
		.valid_s2  (valid_s2),
		.prod_s2   (prod_s2),
		.d_s2      (d_s2),
		.out_valid (out_valid),
		.visible   (visible)
	);

endmodule

`default_nettype wire

// ----- design/fac_checker.sv -----
// ----------------------------------------------------------------------------
// fac_checker
// Port-level checks for the frustum box culler: result hold, reset state,
// stall cause and test-beat latency.
// ----------------------------------------------------------------------------
`default_nettype none

module fac_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic req_type,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic visible
);
	import fac_pkg::*;

	logic test_acc;

	assign test_acc = in_valid && !in_stall && (req_type == REQ_TEST);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(visible))
		else $error("stalled result beat changed");

	// no result right out of reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

	// input stalls only when the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	// a test beat reaches the output when the output does not stall on its way
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		test_acc ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("test beat did not reach output");

endmodule

bind frustum_aabb_cull fac_checker u_fac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.req_type  (req_type),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.visible   (visible)
);

`default_nettype wire

// ----- bench/frustum_aabb_cull_tb.sv -----
// ----------------------------------------------------------------------------
// frustum_aabb_cull testbench
// Loads frustum planes and streams boxes through the culler. Every accepted
// beat is fed to an exact positive-vertex predictor, and each visible flag
// is compared in order against it. Both sides idle at random, one long
// output hold backs the block up, and one pause drains it completely.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fac_pkg::*;

	localparam int BEAT_TARGET  = 1050;
	localparam int QUIET_TAIL   = 150;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 10;
	localparam int STALL_LIMIT  = 2000;

	// q16.16 corner values
	localparam logic [COORD_W-1:0] Q_MIN     = 32'h8000_0000;
	localparam logic [COORD_W-1:0] Q_MAX     = 32'h7fff_ffff;
	localparam logic [COORD_W-1:0] Q_ONE     = 32'h0001_0000;
	localparam logic [COORD_W-1:0] Q_NEG_ONE = 32'hffff_0000;
	localparam logic [COORD_W-1:0] Q_NEG_EPS = 32'hffff_ffff;

	typedef struct {
		req_t              req;
		logic [PIDX_W-1:0] idx;
		plane_t            pl;
		vec3_t             lo;
		vec3_t             hi;
	} cull_beat_t;

	// running plane store and queue of expected visible flags
	class cull_scoreboard;
		plane_t planes[NUM_PLANES];
		bit     vis_q[$];
		int     errors;
		int     loads;
		int     tests;
		int     shown;

		function new();
			foreach (planes[k]) planes[k] = '0;
			errors = 0;
			loads  = 0;
			tests  = 0;
			shown  = 0;
		endfunction

		task report(input string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		// exact a*x + b*y + c*z + d at the positive vertex, sign only
		function bit plane_holds(plane_t p, vec3_t lo, vec3_t hi);
			logic signed [SUM_W-1:0]   acc;
			logic signed [COORD_W-1:0] px, py, pz;
			px = ($signed(p.a) > 0) ? hi.x : lo.x;
			py = ($signed(p.b) > 0) ? hi.y : lo.y;
			pz = ($signed(p.c) > 0) ? hi.z : lo.z;
			acc = '0;
			acc += longint'($signed(p.a)) * longint'(px);
			acc += longint'($signed(p.b)) * longint'(py);
			acc += longint'($signed(p.c)) * longint'(pz);
			acc += longint'($signed(p.d)) <<< FRAC_W;
			return !acc[SUM_W-1];
		endfunction

		function bit box_visible(vec3_t lo, vec3_t hi);
			foreach (planes[k])
				if (!plane_holds(planes[k], lo, hi)) return 1'b0;
			return 1'b1;
		endfunction

		function void note_beat(cull_beat_t b);
			bit vis;
			if (b.req == REQ_LOAD) begin
				loads++;
				if (b.idx < NUM_PLANES) planes[b.idx] = b.pl;
			end else begin
				tests++;
				vis = box_visible(b.lo, b.hi);
				if (vis) shown++;
				vis_q.push_back(vis);
			end
		endfunction

		task check_result(input logic vis);
			bit want;
			if (vis_q.size() == 0) begin
				report($sformatf("visible=%b with no box pending", vis));
				return;
			end
			want = vis_q.pop_front();
			if (vis !== want)
				report($sformatf("visible=%b, predicted %b", vis, want));
		endtask

		task drain_check();
			if (vis_q.size() != 0)
				report($sformatf("%0d boxes never answered", vis_q.size()));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                req_type;
	logic [PIDX_W-1:0]   plane_index;
	logic [COORD_W-1:0]  plane_a, plane_b, plane_c, plane_d;
	logic [COORD_W-1:0]  min_x, min_y, min_z;
	logic [COORD_W-1:0]  max_x, max_y, max_z;
	logic                out_valid;
	logic                out_stall;
	logic                visible;

	cull_scoreboard sb = new();

	int sent        = 0;
	int dead_cycles = 0;
	bit steady_tail = 1'b0;
	bit burst_mode  = 1'b0;
	bit hold_req    = 1'b0;

	frustum_aabb_cull dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.plane_index (plane_index),
		.plane_a     (plane_a),
		.plane_b     (plane_b),
		.plane_c     (plane_c),
		.plane_d     (plane_d),
		.min_x       (min_x),
		.min_y       (min_y),
		.min_z       (min_z),
		.max_x       (max_x),
		.max_y       (max_y),
		.max_z       (max_z),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.visible     (visible)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// beat monitors and watchdog
	always @(posedge clk) begin : watch_ports
		cull_beat_t seen;
		bit         took_in, took_out;
		took_in  = arst_n && in_valid && !in_stall;
		took_out = arst_n && out_valid && !out_stall;
		if (took_in) begin
			seen.req  = req_t'(req_type);
			seen.idx  = plane_index;
			seen.pl   = {plane_a, plane_b, plane_c, plane_d};
			seen.lo   = {min_x, min_y, min_z};
			seen.hi   = {max_x, max_y, max_z};
			sb.note_beat(seen);
		end
		if (took_out) sb.check_result(visible);
		if (took_in || took_out) dead_cycles = 0;
		else if (arst_n) dead_cycles++;
		if (dead_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// result side: random stall bursts, one long hold on request
	initial begin : receiver
		int cyc;
		cyc = 0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (!steady_tail && (cyc / 200) % 2 == 1 && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic pause_input(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// offer one beat, with an occasional gap first, and wait until taken
	task automatic drive_beat(input cull_beat_t b);
		if (!steady_tail && !burst_mode && (sent / 80) % 3 != 0 && $urandom_range(0, 4) == 0)
			pause_input($urandom_range(1, 12));
		req_type    <= b.req;
		plane_index <= b.idx;
		plane_a     <= b.pl.a;
		plane_b     <= b.pl.b;
		plane_c     <= b.pl.c;
		plane_d     <= b.pl.d;
		min_x       <= b.lo.x;
		min_y       <= b.lo.y;
		min_z       <= b.lo.z;
		max_x       <= b.hi.x;
		max_y       <= b.hi.y;
		max_z       <= b.hi.z;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		steady_tail = (sent >= BEAT_TARGET - QUIET_TAIL);
	endtask

	// full range, corner values, or small values near the origin
	function automatic logic [COORD_W-1:0] rand_q();
		logic [COORD_W-1:0] picks[7] = '{Q_MIN, Q_MAX, '0, 32'h1, Q_NEG_EPS, Q_ONE, Q_NEG_ONE};
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return picks[$urandom_range(0, 6)];
			default: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
		endcase
	endfunction

	function automatic cull_beat_t any_beat();
		cull_beat_t b;
		b.req  = req_t'($urandom_range(0, 1));
		b.idx  = PIDX_W'($urandom_range(0, 7));
		b.pl.a = rand_q();
		b.pl.b = rand_q();
		b.pl.c = rand_q();
		b.pl.d = rand_q();
		b.lo.x = rand_q();
		b.lo.y = rand_q();
		b.lo.z = rand_q();
		b.hi.x = rand_q();
		b.hi.y = rand_q();
		b.hi.z = rand_q();
		return b;
	endfunction

	function automatic cull_beat_t load_beat(input int idx,
			input logic [COORD_W-1:0] a, b, c, d);
		cull_beat_t r;
		r      = any_beat();
		r.req  = REQ_LOAD;
		r.idx  = idx[PIDX_W-1:0];
		r.pl.a = a;
		r.pl.b = b;
		r.pl.c = c;
		r.pl.d = d;
		return r;
	endfunction

	function automatic cull_beat_t box_beat(input logic [COORD_W-1:0] lx, ly, lz, hx, hy, hz);
		cull_beat_t r;
		r      = any_beat();
		r.req  = REQ_TEST;
		r.lo.x = lx;
		r.lo.y = ly;
		r.lo.z = lz;
		r.hi.x = hx;
		r.hi.y = hy;
		r.hi.z = hz;
		return r;
	endfunction

	// mostly ordered corners, now and then reversed
	function automatic cull_beat_t box_random();
		logic [COORD_W-1:0] lo3[3], hi3[3], t;
		for (int k = 0; k < 3; k++) begin
			lo3[k] = rand_q();
			hi3[k] = rand_q();
			if ($urandom_range(0, 9) != 0 && $signed(lo3[k]) > $signed(hi3[k])) begin
				t      = lo3[k];
				lo3[k] = hi3[k];
				hi3[k] = t;
			end
		end
		return box_beat(lo3[0], lo3[1], lo3[2], hi3[0], hi3[1], hi3[2]);
	endfunction

	// stimulus
	initial begin : stimulus
		int  active, rot, slot, nbox;
		bit  held, drained;
		held    = 1'b0;
		drained = 1'b0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		req_type    <= REQ_LOAD;
		plane_index <= '0;
		plane_a     <= '0;
		plane_b     <= '0;
		plane_c     <= '0;
		plane_d     <= '0;
		min_x       <= '0;
		min_y       <= '0;
		min_z       <= '0;
		max_x       <= '0;
		max_y       <= '0;
		max_z       <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset planes are all zero: extreme and reversed boxes both pass
		drive_beat(box_beat(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
		drive_beat(box_beat(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
		// positive coefficient picks the max corner
		drive_beat(load_beat(0, Q_MAX, '0, '0, Q_MIN));
		drive_beat(box_beat(Q_MIN, '0, '0, Q_MAX, '0, '0));
		drive_beat(box_beat(Q_MAX, '0, '0, Q_MIN, '0, '0));
		drive_beat(load_beat(0, '0, '0, '0, '0));
		// largest positive and negative sums need the wide accumulator
		drive_beat(load_beat(1, Q_MIN, Q_MIN, Q_MIN, Q_MAX));
		drive_beat(box_beat(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
		drive_beat(load_beat(1, Q_MAX, Q_MAX, Q_MAX, Q_MIN));
		drive_beat(box_beat(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
		// loads to slots past the last plane are dropped
		drive_beat(load_beat(6, '0, '0, '0, Q_NEG_EPS));
		drive_beat(load_beat(7, '0, '0, '0, Q_NEG_EPS));
		drive_beat(load_beat(1, '0, '0, '0, '0));
		drive_beat(box_beat('0, '0, '0, '0, '0, '0));
		// zero coefficients with a slightly negative offset cull everything
		drive_beat(load_beat(3, '0, '0, '0, Q_NEG_EPS));
		drive_beat(box_beat('0, '0, '0, '0, '0, '0));
		// sum exactly zero passes, one lsb either side
		drive_beat(load_beat(3, Q_NEG_ONE, '0, '0, Q_NEG_ONE));
		drive_beat(box_beat(Q_NEG_ONE, '0, '0, '0, '0, '0));
		drive_beat(box_beat(32'hfffe_ffff, '0, '0, '0, '0, '0));
		drive_beat(box_beat(32'hffff_0001, '0, '0, '0, '0, '0));
		drive_beat(load_beat(3, '0, '0, '0, '0));

		// random frames: reload the frustum, then a run of boxes
		while (sent < BEAT_TARGET) begin
			active = $urandom_range(0, NUM_PLANES);
			rot    = $urandom_range(0, NUM_PLANES - 1);
			for (int k = 0; k < NUM_PLANES; k++) begin
				slot = (k + rot) % NUM_PLANES;
				if (k < active)
					drive_beat(load_beat(slot, rand_q(), rand_q(), rand_q(), rand_q()));
				else
					drive_beat(load_beat(slot, '0, '0, '0, $urandom_range(0, Q_MAX)));
			end
			if ($urandom_range(0, 3) == 0)
				drive_beat(load_beat($urandom_range(NUM_PLANES, 7), rand_q(), rand_q(),
					rand_q(), rand_q()));

			// long output hold while boxes keep coming back to back
			if (!held && sent >= 400) begin
				held       = 1'b1;
				hold_req   = 1'b1;
				burst_mode = 1'b1;
				repeat (30) drive_beat(box_random());
				burst_mode = 1'b0;
			end

			// stop offering until the pipeline is empty
			if (!drained && sent >= 700) begin
				drained = 1'b1;
				pause_input(1);
				while (sb.vis_q.size() != 0) @(posedge clk);
			end

			nbox = $urandom_range(8, 30);
			repeat (nbox) begin
				if ($urandom_range(0, 19) == 0) drive_beat(any_beat());
				else drive_beat(box_random());
			end
		end

		// drain and finish
		pause_input(1);
		while (sb.vis_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.drain_check();
		$display("covered %0d plane loads and %0d box tests, %0d visible and %0d culled",
			sb.loads, sb.tests, sb.shown, sb.tests - sb.shown);
		$display("included a %0d-cycle output hold and a full drain pause", HOLD_CYCLES);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- frustum_aabb_cull.f -----
design/fac_pkg.sv
design/fac_plane_store.sv
design/fac_mul_stage.sv
design/fac_sum_stage.sv
design/frustum_aabb_cull.sv
design/fac_checker.sv
bench/frustum_aabb_cull_tb.sv
